// ===== rtl/fsq_pkg.sv =====
// Shared types, constants and color helpers for the fit/scale/quantize blitter.
// No dependencies; imported by every other file of the block except fsq_stream_if.
`default_nettype none

package fsq_pkg;

  // Limits of a usable source image and of the screen
  localparam int unsigned MAX_SOURCE_WIDTH  = 320;
  localparam int unsigned MAX_SOURCE_HEIGHT = 240;
  localparam int unsigned SCREEN_WIDTH      = 256;
  localparam int unsigned SCREEN_ROWS       = 240;

  // Palette layout of the 6x6x6 cube
  localparam int unsigned CUBE_INDEX_BASE = 1;
  localparam int unsigned CUBE_R_STEP     = 36;
  localparam int unsigned CUBE_G_STEP     = 6;
  localparam logic [4:0]  CHAN_MASK       = 5'h1F;

  // Shared divider operand widths
  localparam int unsigned DIV_DVD_W = 18;
  localparam int unsigned DIV_DVS_W = 9;

  typedef enum logic [2:0] {
    CFG_SOURCE_WIDTH  = 3'd0,
    CFG_SOURCE_HEIGHT = 3'd1,
    CFG_BOX_WIDTH     = 3'd2,
    CFG_BOX_HEIGHT    = 3'd3,
    CFG_BOX_LEFT      = 3'd4,
    CFG_BOX_TOP       = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FRAME,
    ST_FDIV,
    ST_EVAL,
    ST_SDIV
  } ctrl_state_e;

  typedef struct packed {
    logic [15:0] source_pixel;
    logic        frame_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0] screen_x;
    logic [7:0] screen_y;
    logic [7:0] color_index;
    logic       last_of_image;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic frame_apply;
    logic frame_div_write;
    logic step_apply;
    logic step_div_write;
  } fsq_cmd_t;

  typedef struct packed {
    logic in_frame_start;
    logic need_frame_div;
    logic skip;
    logic emit;
    logic out_full;
    logic step_div;
    logic div_done;
  } fsq_stat_t;

  // (c*5+15)/31 as a count of thresholds passed
  function automatic logic [2:0] cube_level(input logic [4:0] c);
    logic [2:0] lvl;
    lvl = 3'(c >= 5'd4) + 3'(c >= 5'd10) + 3'(c >= 5'd16) + 3'(c >= 5'd22) + 3'(c >= 5'd28);
    return lvl;
  endfunction

  function automatic logic [7:0] quantize(input logic [15:0] p);
    logic [2:0] r;
    logic [2:0] g;
    logic [2:0] b;
    r = cube_level(p[14:10] & CHAN_MASK);
    g = cube_level(p[9:5] & CHAN_MASK);
    b = cube_level(p[4:0] & CHAN_MASK);
    return 8'(CUBE_INDEX_BASE) + 8'(r) * 8'(CUBE_R_STEP) + 8'(g) * 8'(CUBE_G_STEP) + 8'(b);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fsq_stream_if.sv =====
// Valid/ready stream channel carrying one payload struct per transaction.
// Payload type is set per instance; types come from fsq_pkg.
`default_nettype none

interface fsq_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/fit_scale_quantize_blit_top.sv =====
// Top level of the nearest-neighbor fit/scale/quantize blitter.
// Depends on fsq_pkg, fsq_stream_if, fsq_ctrl, fsq_datapath (with fsq_divider).
//
//   channel   dir   transaction payload
//   pix_i     in    source_pixel[15:0], frame_start
//   res_o     out   screen_x[7:0], screen_y[7:0], color_index[7:0], last_of_image
//   cfg_*     in    write only: cfg_idx_i[2:0], cfg_data_i[8:0] when cfg_we_i
//
// One pixel at a time: a pixel that needs no division is accepted, then evaluated.
// A picked pixel, and the last pixel of a picked row, adds the next-pick division
// in the shared one-bit-per-cycle divider; a frame start adds a setup state, plus
// the height division when the width is scaled down. The result register lets the
// next pixel enter while a result waits; a second result stalls until res_o is
// taken.
// Reset (async, active low) restores the register defaults and zeroes the scan state.
`default_nettype none

module fit_scale_quantize_blit_top
  import fsq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [8:0] cfg_data_i,
  fsq_stream_if.sink   pix_i,
  fsq_stream_if.source res_o
);

  fsq_cmd_t  cmd;
  fsq_stat_t stat;
  logic      res_valid;
  out_item_t res_item;
  in_item_t  pix_item;

  assign pix_item = pix_i.payload;

  fsq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pix_i.valid),
    .in_ready_o (pix_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fsq_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (pix_item),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_valid),
    .out_item_o  (res_item),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

  assign res_o.valid   = res_valid;
  assign res_o.payload = res_item;

  // one pixel in flight: no second accept right after one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.valid && pix_i.ready |=> !pix_i.ready)
    else $error("input accepted while a pixel is in flight");

  // a result is never written over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step_apply && stat.emit |-> !stat.out_full)
    else $error("result register overwritten");

  // quotients are only taken when the divider finishes
  a_div_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.step_div_write || cmd.frame_div_write) |-> stat.div_done)
    else $error("quotient used before divide completed");

  // delivered results stay on screen and in the palette cube
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.payload.color_index >= 8'd1) &&
                    (res_o.payload.color_index <= 8'd216) &&
                    (32'(res_o.payload.screen_y) < SCREEN_ROWS))
    else $error("result out of range");

endmodule

`default_nettype wire

// ===== rtl/fsq_divider.sv =====
// Restoring divider, one quotient bit per cycle, shared by the datapath.
// Depends on fsq_pkg for operand widths.
`default_nettype none

module fsq_divider
  import fsq_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_DVD_W-1:0] dividend_i,
  input  logic [DIV_DVS_W-1:0] divisor_i,
  output logic                 done_o,
  output logic [DIV_DVD_W-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DIV_DVD_W + 1);

  logic [DIV_DVD_W-1:0] quo_q;
  logic [DIV_DVS_W-1:0] rem_q;
  logic [DIV_DVS_W-1:0] dvs_q;
  logic [CntW-1:0]      cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [DIV_DVS_W:0]   trial;
  logic [DIV_DVS_W:0]   trial_sub;
  logic                 ge;

  assign trial     = {rem_q, quo_q[DIV_DVD_W-1]};
  assign ge        = trial >= {1'b0, dvs_q};
  assign trial_sub = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DIV_DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_DVD_W-2:0], ge};
      rem_q <= ge ? trial_sub[DIV_DVS_W-1:0] : trial[DIV_DVS_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== rtl/fsq_datapath.sv =====
// Datapath: configuration registers, scan counters, pick logic, result register.
// Depends on fsq_pkg and instantiates fsq_divider.
`default_nettype none

module fsq_datapath
  import fsq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [8:0] cfg_data_i,
  input  in_item_t  in_item_i,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output out_item_t out_item_o,
  input  fsq_cmd_t  cmd_i,
  output fsq_stat_t stat_o
);

  // configuration
  logic [8:0] src_w_q;
  logic [7:0] src_h_q;
  logic [8:0] box_w_q;
  logic [7:0] box_h_q;
  logic [7:0] box_l_q;
  logic [7:0] box_t_q;

  // scan state
  logic [8:0]  src_col_q;
  logic [7:0]  src_row_q;
  logic [8:0]  out_col_q;
  logic [7:0]  out_row_q;
  logic [8:0]  scl_w_q;
  logic [7:0]  scl_h_q;
  logic [17:0] pick_col_q;
  logic [15:0] pick_row_q;
  logic        div_row_q;

  logic [15:0] pix_q;

  logic      out_valid_q;
  out_item_t out_item_q;

  // pick evaluation
  logic        invalid_src;
  logic        need_div;
  logic        row_picked;
  logic        col_pick;
  logic        row_end;
  logic        step_div;
  logic [9:0]  margin;
  logic [10:0] x_sum;
  logic [8:0]  y_sum;
  logic        visible;
  logic        emit;
  logic        last;

  // divider operands
  logic                 div_start;
  logic [8:0]           mul_a;
  logic [8:0]           mul_b;
  logic [17:0]          product;
  logic [DIV_DVS_W-1:0] div_dvs;
  logic                 div_done;
  logic [DIV_DVD_W-1:0] div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= 9'd160;
      src_h_q <= 8'd120;
      box_w_q <= 9'd91;
      box_h_q <= 8'd107;
      box_l_q <= 8'd99;
      box_t_q <= 8'd15;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SOURCE_WIDTH:  src_w_q <= cfg_data_i;
        CFG_SOURCE_HEIGHT: src_h_q <= cfg_data_i[7:0];
        CFG_BOX_WIDTH:     box_w_q <= cfg_data_i;
        CFG_BOX_HEIGHT:    box_h_q <= cfg_data_i[7:0];
        CFG_BOX_LEFT:      box_l_q <= cfg_data_i[7:0];
        CFG_BOX_TOP:       box_t_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    invalid_src = (src_w_q == '0) || (32'(src_w_q) > MAX_SOURCE_WIDTH) ||
                  (src_h_q == '0) || (32'(src_h_q) > MAX_SOURCE_HEIGHT);
    need_div    = !invalid_src && (src_w_q > box_w_q);

    row_picked = (scl_w_q != '0) && (scl_h_q != '0) && (out_row_q < scl_h_q) &&
                 ({8'd0, src_row_q} == pick_row_q);
    col_pick   = row_picked && (out_col_q < scl_w_q) && ({9'd0, src_col_q} == pick_col_q);
    row_end    = ({1'b0, src_col_q} + 10'd1) >= {1'b0, src_w_q};
    step_div   = row_end ? row_picked : col_pick;

    // centering offset; an underflow lands far off screen
    margin  = {1'b0, box_w_q} - {1'b0, scl_w_q};
    x_sum   = 11'(box_l_q) + 11'(margin[8:1]) + 11'(out_col_q);
    y_sum   = 9'(box_t_q) + 9'(out_row_q);
    visible = !margin[9] && (32'(x_sum) < SCREEN_WIDTH) && (32'(y_sum) < SCREEN_ROWS);
    emit    = col_pick && visible;
    last    = ({1'b0, out_col_q} + 10'd1 == {1'b0, scl_w_q}) &&
              ({1'b0, out_row_q} + 9'd1 == {1'b0, scl_h_q});
  end

  // operand select for the shared multiply/divide
  always_comb begin
    if (cmd_i.frame_apply) begin
      mul_a   = {1'b0, src_h_q};
      mul_b   = box_w_q;
      div_dvs = src_w_q;
    end else if (row_end) begin
      mul_a   = {1'b0, out_row_q + 8'd1};
      mul_b   = {1'b0, src_h_q};
      div_dvs = {1'b0, scl_h_q};
    end else begin
      mul_a   = out_col_q + 9'd1;
      mul_b   = src_w_q;
      div_dvs = scl_w_q;
    end
    product   = 18'(mul_a) * 18'(mul_b);
    div_start = (cmd_i.frame_apply && need_div) || (cmd_i.step_apply && step_div);
  end

  fsq_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (product),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q  <= '0;
      src_row_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      scl_w_q    <= '0;
      scl_h_q    <= '0;
      pick_col_q <= '0;
      pick_row_q <= '0;
      div_row_q  <= 1'b0;
    end else begin
      if (cmd_i.frame_apply) begin
        src_col_q  <= '0;
        src_row_q  <= '0;
        out_col_q  <= '0;
        out_row_q  <= '0;
        pick_col_q <= '0;
        pick_row_q <= '0;
        if (invalid_src) begin
          scl_w_q <= '0;
          scl_h_q <= '0;
        end else if (need_div) begin
          scl_w_q <= box_w_q;
        end else begin
          scl_w_q <= src_w_q;
          scl_h_q <= (src_h_q > box_h_q) ? box_h_q : src_h_q;
        end
      end
      if (cmd_i.frame_div_write) begin
        scl_h_q <= (div_q > 18'(box_h_q)) ? box_h_q : div_q[7:0];
      end
      if (cmd_i.step_apply) begin
        div_row_q <= row_end && row_picked;
        if (col_pick) begin
          out_col_q <= out_col_q + 9'd1;
        end
        if (row_end) begin
          src_col_q  <= '0;
          out_col_q  <= '0;
          pick_col_q <= '0;
          src_row_q  <= src_row_q + 8'd1;
          if (row_picked) begin
            out_row_q <= out_row_q + 8'd1;
          end
        end else begin
          src_col_q <= src_col_q + 9'd1;
        end
      end
      if (cmd_i.step_div_write) begin
        if (div_row_q) begin
          pick_row_q <= div_q[15:0];
        end else begin
          pick_col_q <= div_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pix_q <= in_item_i.source_pixel;
    end
    if (cmd_i.step_apply && emit) begin
      out_item_q.screen_x      <= x_sum[7:0];
      out_item_q.screen_y      <= y_sum[7:0];
      out_item_q.color_index   <= quantize(pix_q);
      out_item_q.last_of_image <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step_apply && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    stat_o.in_frame_start = in_item_i.frame_start;
    stat_o.need_frame_div = need_div;
    stat_o.skip           = src_row_q >= src_h_q;
    stat_o.emit           = emit;
    stat_o.out_full       = out_valid_q;
    stat_o.step_div       = step_div;
    stat_o.div_done       = div_done;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// ===== rtl/fsq_ctrl.sv =====
// Controller state machine: sequences accept, frame setup, pixel step, divides.
// Depends on fsq_pkg for the state enum and the command/status structs.
`default_nettype none

module fsq_ctrl
  import fsq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  fsq_stat_t stat_i,
  output fsq_cmd_t  cmd_o
);

  ctrl_state_e state_q;
  ctrl_state_e state_d;
  logic        stall;

  assign stall = stat_i.emit && stat_i.out_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = stat_i.in_frame_start ? ST_FRAME : ST_EVAL;
        end
      end
      ST_FRAME: state_d = stat_i.need_frame_div ? ST_FDIV : ST_EVAL;
      ST_FDIV: begin
        if (stat_i.div_done) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (stat_i.skip) begin
          state_d = ST_IDLE;
        end else if (!stall) begin
          state_d = stat_i.step_div ? ST_SDIV : ST_IDLE;
        end
      end
      ST_SDIV: begin
        if (stat_i.div_done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o            = 1'b0;
    cmd_o.load            = 1'b0;
    cmd_o.frame_apply     = 1'b0;
    cmd_o.frame_div_write = 1'b0;
    cmd_o.step_apply      = 1'b0;
    cmd_o.step_div_write  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_FRAME: cmd_o.frame_apply     = 1'b1;
      ST_FDIV:  cmd_o.frame_div_write = stat_i.div_done;
      ST_EVAL:  cmd_o.step_apply      = !stat_i.skip && !stall;
      ST_SDIV:  cmd_o.step_div_write  = stat_i.div_done;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== tb/fit_scale_quantize_blit_top_test.sv =====
// Testbench for fit_scale_quantize_blit_top: feeds source pixel streams under random
// stalls and checks every blit against an in-bench scan and quantize predictor.
// Depends on fsq_pkg, fsq_stream_if and the block's RTL.
module fit_scale_quantize_blit_top_test
  import fsq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SETTLE_CYCLES = 64;   // a frame start plus a picked pixel, with margin
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned IMAGE_CAP     = 64;
  localparam int unsigned RANDOM_PIXELS = 360;

  logic       clk_i  = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we;
  logic [2:0] cfg_idx;
  logic [8:0] cfg_data;

  fsq_stream_if #(.payload_t(in_item_t))  pix_if ();
  fsq_stream_if #(.payload_t(out_item_t)) res_if ();

  fit_scale_quantize_blit_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix_if),
    .res_o      (res_if)
  );

  always #5 clk_i = ~clk_i;

  bit steady    = 1'b0;   // no idling on either side
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;

  int unsigned mismatches = 0;
  out_item_t   pending_blits[$];

  // predictor copy of the registers and of the scan state
  logic [8:0] src_w, box_w, col, out_col, fit_w, pick_col;
  logic [7:0] src_h, box_h, box_l, box_t, row, out_row, fit_h, pick_row;

  task automatic reset_model();
    src_w = 9'd160; src_h = 8'd120; box_w = 9'd91; box_h = 8'd107; box_l = 8'd99; box_t = 8'd15;
    col = '0; row = '0; out_col = '0; out_row = '0;
    fit_w = '0; fit_h = '0; pick_col = '0; pick_row = '0;
  endtask

  task automatic latch_register(input cfg_idx_e which, input logic [8:0] v);
    case (which)
      CFG_SOURCE_WIDTH:  src_w = v;
      CFG_SOURCE_HEIGHT: src_h = v[7:0];
      CFG_BOX_WIDTH:     box_w = v;
      CFG_BOX_HEIGHT:    box_h = v[7:0];
      CFG_BOX_LEFT:      box_l = v[7:0];
      CFG_BOX_TOP:       box_t = v[7:0];
      default: ;
    endcase
  endtask

  function automatic logic [7:0] palette_index(input logic [15:0] px);
    int unsigned r, g, b;
    r = (32'(px[14:10]) * 5 + 15) / 31;
    g = (32'(px[9:5]) * 5 + 15) / 31;
    b = (32'(px[4:0]) * 5 + 15) / 31;
    return 8'(CUBE_INDEX_BASE + r * CUBE_R_STEP + g * CUBE_G_STEP + b);
  endfunction

  task automatic track_pixel(input logic [15:0] px, input logic fs);
    int unsigned x, y, iw, ih;
    bit          row_hit;
    out_item_t   blit;
    if (fs) begin
      col = '0; row = '0; out_col = '0; out_row = '0; pick_col = '0; pick_row = '0;
      iw = src_w;
      ih = src_h;
      if (iw == 0 || iw > MAX_SOURCE_WIDTH || ih == 0 || ih > MAX_SOURCE_HEIGHT) begin
        iw = 0;
        ih = 0;
      end else begin
        if (iw > box_w) begin
          ih = ih * box_w / iw;
          iw = box_w;
        end
        if (ih > box_h) ih = box_h;
      end
      fit_w = 9'(iw);
      fit_h = 8'(ih);
    end
    if (row >= src_h) return;   // past the last row: ignored

    row_hit = fit_w != 0 && fit_h != 0 && out_row < fit_h && row == pick_row;
    if (row_hit && out_col < fit_w && col == pick_col) begin
      x = 32'(box_l) + (32'(box_w) - 32'(fit_w)) / 2 + 32'(out_col);
      y = 32'(box_t) + 32'(out_row);
      if (x < SCREEN_WIDTH && y < SCREEN_ROWS) begin
        blit.screen_x      = 8'(x);
        blit.screen_y      = 8'(y);
        blit.color_index   = palette_index(px);
        blit.last_of_image = (32'(out_col) + 1 == fit_w) && (32'(out_row) + 1 == fit_h);
        pending_blits.push_back(blit);
      end
      out_col++;
      pick_col = 9'(32'(out_col) * 32'(src_w) / 32'(fit_w));
    end

    if (32'(col) + 1 >= 32'(src_w)) begin
      col = '0;
      if (row_hit) begin
        out_row++;
        pick_row = 8'(32'(out_row) * 32'(src_h) / 32'(fit_h));
      end
      out_col  = '0;
      pick_col = '0;
      row++;
    end else begin
      col++;
    end
  endtask

  // call only while the block is idle
  task automatic set_config(input logic [8:0] sw, sh, bw, bh, bl, bt);
    cfg_idx_e   which [6];
    logic [8:0] value [6];
    which = '{CFG_SOURCE_WIDTH, CFG_SOURCE_HEIGHT, CFG_BOX_WIDTH,
              CFG_BOX_HEIGHT, CFG_BOX_LEFT, CFG_BOX_TOP};
    value = '{sw, sh, bw, bh, bl, bt};
    for (int i = 0; i < 6; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= which[i];
      cfg_data <= value[i];
      @(posedge clk_i);
      latch_register(which[i], value[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_pixel(input logic [15:0] px, input logic fs);
    if (!steady && $urandom_range(99) < 31) begin
      pix_if.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    pix_if.valid   <= 1'b1;
    pix_if.payload <= '{source_pixel: px, frame_start: fs};
    do @(posedge clk_i); while (!pix_if.ready);
    track_pixel(px, fs);
  endtask

  task automatic wait_results();
    pix_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_blits.size() != 0);
  endtask

  // idle input, all blits out, and time for a pixel that gives none to finish
  task automatic quiesce();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [8:0] pick_dim(input int unsigned top_ok, input int unsigned typical,
                                          input int unsigned reg_max);
    case ($urandom_range(15))
      0:       return 9'd1;
      1:       return 9'(top_ok);
      2:       return 9'($urandom_range(reg_max));
      default: return 9'($urandom_range(typical, 1));
    endcase
  endfunction

  task automatic send_random_image(inout int unsigned fed);
    int unsigned span, n;
    span = 32'(src_w) * 32'(src_h);
    if (span == 0) span = 4;
    if (span > IMAGE_CAP) span = IMAGE_CAP;
    n = span;
    case ($urandom_range(9))
      0:       n = span + $urandom_range(4, 1);   // runs past the last row
      1:       n = $urandom_range(span, 1);       // cut short by the next frame
      default: ;
    endcase
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(39) == 0) wait_results();
      send_pixel(16'($urandom), i == 0 || $urandom_range(99) == 0);
    end
    fed += span;
  endtask

  task automatic test_no_frame_yet();
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0000, 1'b0);
    quiesce();
  endtask

  task automatic test_small_image();
    set_config(9'd3, 9'd2, 9'd3, 9'd240, 9'd0, 9'd0);
    send_pixel(16'h0000, 1'b1);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h7FFF, 1'b0);
    send_pixel(16'h8000, 1'b0);
    send_pixel(16'h5294, 1'b0);
    send_pixel(16'h0421, 1'b0);
    send_pixel(16'h1234, 1'b0);   // extra pixel, no new frame
    quiesce();
  endtask

  task automatic test_empty_source();
    set_config(9'd0, 9'd2, 9'd8, 9'd8, 9'd10, 9'd10);
    send_pixel(16'h3C0F, 1'b1);
    quiesce();
    set_config(9'd321, 9'd2, 9'd8, 9'd8, 9'd10, 9'd10);
    send_pixel(16'h3C0F, 1'b1);
    quiesce();
    set_config(9'd4, 9'd0, 9'd8, 9'd8, 9'd10, 9'd10);
    send_pixel(16'h3C0F, 1'b1);
    quiesce();
    set_config(9'd4, 9'd241, 9'd8, 9'd8, 9'd10, 9'd10);
    send_pixel(16'h3C0F, 1'b1);
    quiesce();
  endtask

  task automatic test_zero_scale();
    set_config(9'd100, 9'd1, 9'd50, 9'd8, 9'd10, 9'd10);   // height rounds to zero
    send_pixel(16'h7C00, 1'b1);
    quiesce();
    set_config(9'd4, 9'd4, 9'd0, 9'd8, 9'd10, 9'd10);      // box of no width
    send_pixel(16'h03E0, 1'b1);
    quiesce();
  endtask

  task automatic test_clipped_edge();
    // second column lands at x = 256, off screen, so no blit carries the end-of-image flag
    set_config(9'd2, 9'd1, 9'd2, 9'd8, 9'd255, 9'd239);
    send_pixel(16'h001F, 1'b1);
    send_pixel(16'h7FE0, 1'b0);
    quiesce();
  endtask

  task automatic test_midimage_change();
    set_config(9'd2, 9'd2, 9'd2, 9'd2, 9'd40, 9'd30);
    send_pixel(16'h4210, 1'b1);
    send_pixel(16'h2108, 1'b0);
    quiesce();
    set_config(9'd2, 9'd2, 9'd2, 9'd2, 9'd200, 9'd100);
    send_pixel(16'h6318, 1'b0);
    send_pixel(16'h739C, 1'b0);
    quiesce();
  endtask

  task automatic test_extremes();
    set_config(9'd320, 9'd240, 9'd256, 9'd240, 9'd0, 9'd0);
    for (int i = 0; i < 6; i++) send_pixel(16'($urandom), i == 0);
    quiesce();
    set_config(9'd1, 9'd1, 9'd1, 9'd1, 9'd255, 9'd239);
    send_pixel(16'hFFFF, 1'b1);
    quiesce();
  endtask

  task automatic test_backpressure();
    set_config(9'd8, 9'd5, 9'd16, 9'd16, 9'd20, 9'd20);
    hold_req <= 1'b1;
    for (int i = 0; i < 40; i++) send_pixel(16'($urandom), i == 0);
    quiesce();
  endtask

  task automatic test_random_images();
    int unsigned fed, phase;
    logic [8:0]  left, top;
    fed   = 0;
    phase = 0;
    while (fed < RANDOM_PIXELS) begin
      steady <= (phase >= 1 && phase < 3);
      case ($urandom_range(7))
        0:       left = 9'd0;
        1:       left = 9'd255;
        default: left = 9'($urandom_range(200));
      endcase
      case ($urandom_range(7))
        0:       top = 9'd0;
        1:       top = 9'd239;
        2:       top = 9'($urandom_range(255, 240));
        default: top = 9'($urandom_range(220));
      endcase
      set_config(pick_dim(320, 12, 511), pick_dim(240, 8, 255),
                 pick_dim(256, 16, 511), pick_dim(240, 12, 255), left, top);
      repeat ($urandom_range(3, 1)) send_random_image(fed);
      quiesce();
      phase++;
    end
    steady <= 1'b0;
  endtask

  initial begin
    cfg_we         <= 1'b0;
    cfg_idx        <= CFG_SOURCE_WIDTH;
    cfg_data       <= '0;
    pix_if.valid   <= 1'b0;
    pix_if.payload <= '0;
    reset_model();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_no_frame_yet();
    test_small_image();
    test_empty_source();
    test_zero_scale();
    test_clipped_edge();
    test_midimage_change();
    test_extremes();
    test_backpressure();
    test_random_images();
    quiesce();

    if (mismatches == 0 && pending_blits.size() == 0)
      $display("fit_scale_quantize_blit_top test passed");
    else
      $display("fit_scale_quantize_blit_top test failed");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int unsigned held;
    held = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        res_if.ready <= 1'b0;
        held++;
        if (held == HOLD_CYCLES) hold_done <= 1'b1;
      end else if (steady) begin
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= ($urandom_range(99) >= 31);
      end
    end
  end

  always @(posedge clk_i) begin : check_blit
    out_item_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_blits.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected blit x=%0d y=%0d color=%0d last=%0b", $time,
                 res_if.payload.screen_x, res_if.payload.screen_y,
                 res_if.payload.color_index, res_if.payload.last_of_image);
      end else begin
        want = pending_blits.pop_front();
        if (res_if.payload !== want) begin
          mismatches++;
          $display({"%0t: blit mismatch: expected x=%0d y=%0d color=%0d last=%0b, ",
                    "got x=%0d y=%0d color=%0d last=%0b"},
                   $time, want.screen_x, want.screen_y, want.color_index, want.last_of_image,
                   res_if.payload.screen_x, res_if.payload.screen_y,
                   res_if.payload.color_index, res_if.payload.last_of_image);
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("fit_scale_quantize_blit_top test failed");
    $finish;
  end

endmodule
